### design/ccg_pkg.sv
// ----------------------------------------------------------------------------
// ccg_pkg
// Types, register codes and the contour unit-vector function shared by the
// circle contour to grid cell block and its checker.
// ----------------------------------------------------------------------------
package ccg_pkg;

    localparam int SEGMENTS_DEFAULT = 32;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 32;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_WIDTH,
        REG_MAP_HEIGHT,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_COS,
        REG_ORIGIN_SIN,
        REG_CELLS_PER_METER
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [30:0] circle_radius;
    } circle_t;

    typedef struct packed {
        logic [23:0] cell_index;
        logic        in_map;
        logic        last_point;
    } cell_t;

    // sign and magnitude of one contour direction, magnitude in Q1.30
    typedef struct packed {
        logic        cos_neg;
        logic [30:0] cos_mag;
        logic        sin_neg;
        logic [30:0] sin_mag;
    } unit_vec_t;

    function automatic longint clamp_unit(input longint v);
        longint r;
        r = v;
        if (v < 0)
        begin
            r = 0;
        end
        else if (v > ONE_Q30)
        begin
            r = ONE_Q30;
        end
        return r;
    endfunction

    // taylor series on the first quadrant, then quadrant fold
    function automatic unit_vec_t unit_vec(input longint unsigned angle, input logic [1:0] quad);
        longint unsigned t2;
        longint unsigned term;
        longint          sn;
        longint          cs;
        longint          cc;
        longint          ss;
        longint          uc;
        longint          us;
        unit_vec_t       uv;
        t2   = (angle * angle) >> 30;
        term = angle;
        sn   = longint'(angle);
        term = ((term * t2) >> 30) / 6;
        sn   = sn - longint'(term);
        term = ((term * t2) >> 30) / 20;
        sn   = sn + longint'(term);
        term = ((term * t2) >> 30) / 42;
        sn   = sn - longint'(term);
        term = ((term * t2) >> 30) / 72;
        sn   = sn + longint'(term);
        term = ((term * t2) >> 30) / 110;
        sn   = sn - longint'(term);
        term = longint'(ONE_Q30);
        cs   = ONE_Q30;
        term = ((term * t2) >> 30) / 2;
        cs   = cs - longint'(term);
        term = ((term * t2) >> 30) / 12;
        cs   = cs + longint'(term);
        term = ((term * t2) >> 30) / 30;
        cs   = cs - longint'(term);
        term = ((term * t2) >> 30) / 56;
        cs   = cs + longint'(term);
        term = ((term * t2) >> 30) / 90;
        cs   = cs - longint'(term);
        cc = clamp_unit(cs);
        ss = clamp_unit(sn);
        case (quad)
            2'd0:
            begin
                uc = cc;
                us = ss;
            end
            2'd1:
            begin
                uc = -ss;
                us = cc;
            end
            2'd2:
            begin
                uc = -cc;
                us = -ss;
            end
            default:
            begin
                uc = ss;
                us = -cc;
            end
        endcase
        uv.cos_neg = (uc < 0);
        uv.cos_mag = 31'((uc < 0) ? -uc : uc);
        uv.sin_neg = (us < 0);
        uv.sin_mag = 31'((us < 0) ? -us : us);
        return uv;
    endfunction

endpackage

### design/circle_contour_to_grid_cells.sv
// ----------------------------------------------------------------------------
// circle_contour_to_grid_cells
// Walks the contour of a circle and gives the occupancy grid cell of each of
// its SEGMENTS+1 points, flagged when outside the map.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload    handshake
//  circle    in         circle_t   circle_valid / circle_stall
//  cell      out        cell_t     cell_valid / cell_stall
//  cfg       in         32 bit     cfg_write, cfg_index
//
//  The point counter issues one contour point per cycle while the pipeline
//  advances; the next circle is taken as the last point issues.
//  Ten register stages from point issue to the output register.
//  Reset clears the valid bits and loads the register defaults; no clearing pass.
//  A stall on a held output cell freezes the whole pipeline, bubbles included.
//
module circle_contour_to_grid_cells
    import ccg_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   circle_valid,
    output logic                   circle_stall,
    input  circle_t                circle_data,
    output logic                   cell_valid,
    input  logic                   cell_stall,
    output cell_t                  cell_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(SEGMENTS + 1);

    // configuration
    logic        [12:0] map_width_reg;
    logic        [12:0] map_height_reg;
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic signed [15:0] origin_cos_reg;
    logic signed [15:0] origin_sin_reg;
    logic        [31:0] cells_per_meter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg       <= 13'd256;
            map_height_reg      <= 13'd256;
            origin_x_reg        <= 32'sd0;
            origin_y_reg        <= 32'sd0;
            origin_cos_reg      <= 16'sd16384;
            origin_sin_reg      <= 16'sd0;
            cells_per_meter_reg <= 32'd1310720;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAP_WIDTH:       map_width_reg       <= cfg_data[12:0];
                REG_MAP_HEIGHT:      map_height_reg      <= cfg_data[12:0];
                REG_ORIGIN_X:        origin_x_reg        <= $signed(cfg_data);
                REG_ORIGIN_Y:        origin_y_reg        <= $signed(cfg_data);
                REG_ORIGIN_COS:      origin_cos_reg      <= $signed(cfg_data[15:0]);
                REG_ORIGIN_SIN:      origin_sin_reg      <= $signed(cfg_data[15:0]);
                REG_CELLS_PER_METER: cells_per_meter_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // contour direction table
    unit_vec_t rom_uv [0:SEGMENTS];

    for (genvar g = 0; g <= SEGMENTS; g++)
    begin : g_rom
        localparam int unsigned     QUAD  = (4 * g) / SEGMENTS;
        localparam int unsigned     REM   = 4 * g - QUAD * SEGMENTS;
        localparam longint unsigned ANGLE = (HALF_PI_Q30 * REM + SEGMENTS / 2) / SEGMENTS;
        localparam unit_vec_t       UV    = unit_vec(ANGLE, QUAD[1:0]);
        assign rom_uv[g] = UV;
    end

    // pipeline advance
    logic adv;
    logic out_valid_reg;
    cell_t cell_data_reg;

    assign adv = !out_valid_reg || !cell_stall;

    // point generator
    logic                     gen_busy_reg;
    logic [IDX_W-1:0]         gen_idx_reg;
    logic signed [31:0]       gen_cx_reg;
    logic signed [31:0]       gen_cy_reg;
    logic [30:0]              gen_rad_reg;
    logic                     gen_last;
    logic                     circle_accept;

    assign gen_last      = (gen_idx_reg == IDX_W'(SEGMENTS));
    assign circle_stall  = gen_busy_reg && !(adv && gen_last);
    assign circle_accept = circle_valid && !circle_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_busy_reg <= 1'b0;
            gen_idx_reg  <= '0;
        end
        else if (circle_accept)
        begin
            gen_busy_reg <= 1'b1;
            gen_idx_reg  <= '0;
        end
        else if (gen_busy_reg && adv)
        begin
            if (gen_last)
            begin
                gen_busy_reg <= 1'b0;
            end
            else
            begin
                gen_idx_reg <= gen_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (circle_accept)
        begin
            gen_cx_reg  <= circle_data.center_x;
            gen_cy_reg  <= circle_data.center_y;
            gen_rad_reg <= circle_data.circle_radius;
        end
    end

    // valid and last bits travel down stages 1 to 9
    logic [9:1] vld_reg;
    logic [9:1] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[8:1], gen_busy_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[8:1], gen_last};
        end
    end

    // stage 1: direction lookup, center minus origin
    unit_vec_t          s1_uv_reg;
    logic [30:0]        s1_rad_reg;
    logic signed [32:0] s1_dx_reg;
    logic signed [32:0] s1_dy_reg;

    // stage 2: radius products
    logic [61:0]        s2_cprod_reg;
    logic [61:0]        s2_sprod_reg;
    logic               s2_cneg_reg;
    logic               s2_sneg_reg;
    logic signed [32:0] s2_dx_reg;
    logic signed [32:0] s2_dy_reg;

    // stage 3: rounded offsets
    logic [30:0]        s3_coff_reg;
    logic [30:0]        s3_soff_reg;
    logic               s3_cneg_reg;
    logic               s3_sneg_reg;
    logic signed [32:0] s3_dx_reg;
    logic signed [32:0] s3_dy_reg;

    // stage 4: point in origin frame
    logic signed [33:0] s4_xt_reg;
    logic signed [33:0] s4_yt_reg;
    logic signed [33:0] s4_cadd;
    logic signed [33:0] s4_sadd;

    // stage 5: rotation products
    logic signed [49:0] s5_xc_reg;
    logic signed [49:0] s5_xs_reg;
    logic signed [49:0] s5_yc_reg;
    logic signed [49:0] s5_ys_reg;

    // stage 6: rotated point
    logic signed [50:0] s6_xr_reg;
    logic signed [50:0] s6_yr_reg;

    // stage 7: scale partial products
    logic               s7_pos_reg;
    logic [56:0]        s7_xa_reg;
    logic [56:0]        s7_xb_reg;
    logic [56:0]        s7_ya_reg;
    logic [56:0]        s7_yb_reg;

    // stage 8: column and row
    logic               s8_pos_reg;
    logic [35:0]        s8_col_reg;
    logic [35:0]        s8_row_reg;

    // stage 9: bounds check
    logic               s9_inside_reg;
    logic [12:0]        s9_col_reg;
    logic [12:0]        s9_row_reg;

    logic [23:0]        out_index;

    always_comb
    begin
        s4_cadd = $signed({3'b000, s3_coff_reg});
        s4_sadd = $signed({3'b000, s3_soff_reg});
        if (s3_cneg_reg)
        begin
            s4_cadd = -s4_cadd;
        end
        if (s3_sneg_reg)
        begin
            s4_sadd = -s4_sadd;
        end
    end

    assign out_index = 24'(s9_row_reg) * 24'(map_width_reg) + 24'(s9_col_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_uv_reg    <= rom_uv[gen_idx_reg];
            s1_rad_reg   <= gen_rad_reg;
            s1_dx_reg    <= 33'(gen_cx_reg) - 33'(origin_x_reg);
            s1_dy_reg    <= 33'(gen_cy_reg) - 33'(origin_y_reg);

            s2_cprod_reg <= 62'(s1_rad_reg) * 62'(s1_uv_reg.cos_mag);
            s2_sprod_reg <= 62'(s1_rad_reg) * 62'(s1_uv_reg.sin_mag);
            s2_cneg_reg  <= s1_uv_reg.cos_neg;
            s2_sneg_reg  <= s1_uv_reg.sin_neg;
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;

            s3_coff_reg  <= 31'((s2_cprod_reg + 62'(1 << 29)) >> 30);
            s3_soff_reg  <= 31'((s2_sprod_reg + 62'(1 << 29)) >> 30);
            s3_cneg_reg  <= s2_cneg_reg;
            s3_sneg_reg  <= s2_sneg_reg;
            s3_dx_reg    <= s2_dx_reg;
            s3_dy_reg    <= s2_dy_reg;

            s4_xt_reg    <= 34'(s3_dx_reg) + s4_cadd;
            s4_yt_reg    <= 34'(s3_dy_reg) + s4_sadd;

            s5_xc_reg    <= 50'(s4_xt_reg) * 50'(origin_cos_reg);
            s5_xs_reg    <= 50'(s4_xt_reg) * 50'(origin_sin_reg);
            s5_yc_reg    <= 50'(s4_yt_reg) * 50'(origin_cos_reg);
            s5_ys_reg    <= 50'(s4_yt_reg) * 50'(origin_sin_reg);

            s6_xr_reg    <= 51'(s5_xc_reg) + 51'(s5_ys_reg);
            s6_yr_reg    <= 51'(s5_yc_reg) - 51'(s5_xs_reg);

            s7_pos_reg   <= !s6_xr_reg[50] && !s6_yr_reg[50];
            s7_xa_reg    <= 57'(s6_xr_reg[49:25]) * 57'(cells_per_meter_reg);
            s7_xb_reg    <= 57'(s6_xr_reg[24:0]) * 57'(cells_per_meter_reg);
            s7_ya_reg    <= 57'(s6_yr_reg[49:25]) * 57'(cells_per_meter_reg);
            s7_yb_reg    <= 57'(s6_yr_reg[24:0]) * 57'(cells_per_meter_reg);

            s8_pos_reg   <= s7_pos_reg;
            s8_col_reg   <= 36'((58'(s7_xa_reg) + 58'(s7_xb_reg >> 25)) >> 21);
            s8_row_reg   <= 36'((58'(s7_ya_reg) + 58'(s7_yb_reg >> 25)) >> 21);

            s9_inside_reg <= s8_pos_reg
                             && (s8_col_reg[35:13] == '0) && (s8_row_reg[35:13] == '0)
                             && (s8_col_reg[12:0] < map_width_reg)
                             && (s8_row_reg[12:0] < map_height_reg);
            s9_col_reg   <= s8_col_reg[12:0];
            s9_row_reg   <= s8_row_reg[12:0];

            cell_data_reg.cell_index <= s9_inside_reg ? out_index : 24'd0;
            cell_data_reg.in_map     <= s9_inside_reg;
            cell_data_reg.last_point <= last_reg[9];
        end
    end

    // stage 10: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[9];
        end
    end

    assign cell_valid = out_valid_reg;
    assign cell_data  = cell_data_reg;

endmodule

### design/ccg_checker.sv
// ----------------------------------------------------------------------------
// ccg_checker
// Port-level checks on the circle contour to grid cell block.
// ----------------------------------------------------------------------------
module ccg_checker
    import ccg_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  circle_valid,
    input logic  circle_stall,
    input logic  cell_valid,
    input logic  cell_stall,
    input cell_t cell_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |=> cell_valid && $stable(cell_data))
    else $error("cell transaction changed while stalled");

    // outside points carry index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid |-> (cell_data.in_map || (cell_data.cell_index == 24'd0)))
    else $error("outside point with nonzero cell index");

    // a taken circle keeps the generator busy and stalls the next circle
    assert property (@(posedge clk) disable iff (!rst_n)
        circle_valid && !circle_stall |=> circle_stall)
    else $error("circle taken right after a circle transaction");

endmodule

bind circle_contour_to_grid_cells ccg_checker u_ccg_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for circle_contour_to_grid_cells. Circles are driven
// through the valid/stall channel; each accepted one is expanded into its
// contour cells by an independent fixed-point predictor inside a small
// scoreboard, and every cell transaction is compared in order. The run walks
// through several map settings, including degenerate and extreme ones, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import ccg_pkg::*;

    localparam int SEGMENTS        = SEGMENTS_DEFAULT;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint          UNIT_Q30         = 64'sd1073741824;

    class grid_cell_scoreboard;
        cell_t       expected_cells[$];
        int          mismatches;
        logic [12:0] map_w;
        logic [12:0] map_h;
        logic [31:0] org_x;
        logic [31:0] org_y;
        logic [15:0] rot_cos;
        logic [15:0] rot_sin;
        logic [31:0] cpm;
        longint      dir_cos[SEGMENTS+1];
        longint      dir_sin[SEGMENTS+1];

        function new();
            longint unsigned quad;
            longint unsigned rem;
            longint unsigned t;
            longint unsigned t2;
            longint unsigned term;
            longint unsigned div;
            longint          sn;
            longint          cs;
            longint          cc;
            longint          ss;
            mismatches = 0;
            map_w      = 13'd256;
            map_h      = 13'd256;
            org_x      = '0;
            org_y      = '0;
            rot_cos    = 16'd16384;
            rot_sin    = '0;
            cpm        = 32'd1310720;
            // contour directions: first-quadrant series, then quadrant fold
            for (int i = 0; i <= SEGMENTS; i++)
            begin
                quad = (4 * i) / SEGMENTS;
                rem  = 4 * i - quad * SEGMENTS;
                t    = (QUARTER_TURN_Q30 * rem + SEGMENTS / 2) / SEGMENTS;
                t2   = (t * t) >> 30;
                term = t;
                sn   = longint'(t);
                for (int k = 1; k <= 5; k++)
                begin
                    div  = 2 * k * (2 * k + 1);
                    term = ((term * t2) >> 30) / div;
                    sn   = (k % 2 == 1) ? sn - longint'(term) : sn + longint'(term);
                end
                term = UNIT_Q30;
                cs   = UNIT_Q30;
                for (int k = 1; k <= 5; k++)
                begin
                    div  = (2 * k - 1) * (2 * k);
                    term = ((term * t2) >> 30) / div;
                    cs   = (k % 2 == 1) ? cs - longint'(term) : cs + longint'(term);
                end
                cc = (cs < 0) ? 64'sd0 : ((cs > UNIT_Q30) ? UNIT_Q30 : cs);
                ss = (sn < 0) ? 64'sd0 : ((sn > UNIT_Q30) ? UNIT_Q30 : sn);
                case (quad % 4)
                    0:
                    begin
                        dir_cos[i] = cc;
                        dir_sin[i] = ss;
                    end
                    1:
                    begin
                        dir_cos[i] = -ss;
                        dir_sin[i] = cc;
                    end
                    2:
                    begin
                        dir_cos[i] = -cc;
                        dir_sin[i] = -ss;
                    end
                    default:
                    begin
                        dir_cos[i] = ss;
                        dir_sin[i] = -cc;
                    end
                endcase
            end
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MAP_WIDTH:       map_w   = value[12:0];
                REG_MAP_HEIGHT:      map_h   = value[12:0];
                REG_ORIGIN_X:        org_x   = value;
                REG_ORIGIN_Y:        org_y   = value;
                REG_ORIGIN_COS:      rot_cos = value[15:0];
                REG_ORIGIN_SIN:      rot_sin = value[15:0];
                REG_CELLS_PER_METER: cpm     = value;
                default:             ;
            endcase
        endfunction

        // radius times unit direction, rounded half away from zero
        function longint radial(longint unsigned r, longint u);
            longint unsigned m;
            longint unsigned p;
            m = (u < 0) ? -u : u;
            p = (r * m + (64'd1 << 29)) >> 30;
            return (u < 0) ? -longint'(p) : longint'(p);
        endfunction

        function longint unsigned grid_cell(longint unsigned v, longint unsigned k);
            longint unsigned a;
            longint unsigned b;
            a = (v >> 25) * k;
            b = (v & 64'h1FF_FFFF) * k;
            return (a + (b >> 25)) >> 21;
        endfunction

        function void note_circle(circle_t c);
            longint          cx;
            longint          cy;
            longint          ox;
            longint          oy;
            longint          oc;
            longint          os;
            longint          xt;
            longint          yt;
            longint          xr;
            longint          yr;
            longint unsigned rad;
            longint unsigned col;
            longint unsigned row;
            longint unsigned idx;
            cell_t           e;
            cx  = $signed(c.center_x);
            cy  = $signed(c.center_y);
            rad = c.circle_radius;
            ox  = $signed(org_x);
            oy  = $signed(org_y);
            oc  = $signed(rot_cos);
            os  = $signed(rot_sin);
            for (int i = 0; i <= SEGMENTS; i++)
            begin
                xt = cx + radial(rad, dir_cos[i]) - ox;
                yt = cy + radial(rad, dir_sin[i]) - oy;
                xr = xt * oc + yt * os;
                yr = yt * oc - xt * os;
                e  = '0;
                if (xr >= 0 && yr >= 0)
                begin
                    col = grid_cell(xr, cpm);
                    row = grid_cell(yr, cpm);
                    if (col < map_w && row < map_h)
                    begin
                        idx          = row * map_w + col;
                        e.in_map     = 1'b1;
                        e.cell_index = idx[23:0];
                    end
                end
                e.last_point = (i == SEGMENTS);
                expected_cells.insert(expected_cells.size(), e);
            end
        endfunction

        function void check_cell(cell_t got);
            cell_t want;
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected cell transaction: index %0d in_map %0b last %0b",
                             got.cell_index, got.in_map, got.last_point);
                return;
            end
            want = expected_cells.pop_front();
            if (got.cell_index !== want.cell_index || got.in_map !== want.in_map ||
                got.last_point !== want.last_point)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"cell mismatch: expected index %0d in_map %0b last %0b,",
                              " got %0d %0b %0b"},
                             want.cell_index, want.in_map, want.last_point,
                             got.cell_index, got.in_map, got.last_point);
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   circle_valid;
    logic                   circle_stall;
    circle_t                circle_data;
    logic                   cell_valid;
    logic                   cell_stall;
    cell_t                  cell_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    grid_cell_scoreboard cell_board;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  hold_off_left = 0;
    int                  quiet_cycles  = 0;

    circle_contour_to_grid_cells #(
        .SEGMENTS (SEGMENTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .circle_valid (circle_valid),
        .circle_stall (circle_stall),
        .circle_data  (circle_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall, or a counted hold-off when one is requested
    initial
    begin
        cell_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                cell_stall <= 1'b1;
                hold_off_left--;
            end
            else
            begin
                cell_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if ((circle_valid && !circle_stall) || (cell_valid && !cell_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (circle_valid && !circle_stall)
            cell_board.note_circle(circle_data);
        if (cell_valid && !cell_stall)
            cell_board.check_cell(cell_data);
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cell_board.set_reg(idx, value);
        @(negedge clk);
    endtask

    // unused upper data bits carry random junk
    task automatic configure_map(input logic [12:0] w, input logic [12:0] h,
                                 input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [15:0] rc, input logic [15:0] rs,
                                 input logic [31:0] cpm);
        write_reg(REG_MAP_WIDTH, {19'($urandom), w});
        write_reg(REG_MAP_HEIGHT, {19'($urandom), h});
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_ORIGIN_COS, {16'($urandom), rc});
        write_reg(REG_ORIGIN_SIN, {16'($urandom), rs});
        write_reg(REG_CELLS_PER_METER, cpm);
        cfg_write <= 1'b0;
    endtask

    task automatic send_circle(input circle_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            circle_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        circle_valid <= 1'b1;
        circle_data  <= c;
        @(posedge clk);
        while (circle_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly circles placed around the current map, some pure noise
    function automatic circle_t random_circle();
        circle_t         c;
        longint unsigned cells;
        longint unsigned span;
        longint          u;
        longint          v;
        longint          rc;
        longint          rs;
        longint          px;
        longint          py;
        int              pick;
        pick            = $urandom_range(99);
        c.center_x      = $urandom;
        c.center_y      = $urandom;
        c.circle_radius = 31'($urandom);
        if (pick >= 15)
        begin
            cells = (cell_board.map_w > cell_board.map_h) ? cell_board.map_w : cell_board.map_h;
            if (cells == 0)
                cells = 1;
            if (cell_board.cpm == 0)
                span = 64'd1 << 22;
            else
                span = (cells << 32) / cell_board.cpm;
            if (span > (64'd1 << 30))
                span = 64'd1 << 30;
            if (span < 64)
                span = 64;
            u  = longint'($urandom_range(32'(span + span / 4))) - longint'(span / 8);
            v  = longint'($urandom_range(32'(span + span / 4))) - longint'(span / 8);
            rc = $signed(cell_board.rot_cos);
            rs = $signed(cell_board.rot_sin);
            px = $signed(cell_board.org_x) + ((rc * u - rs * v) >>> 14);
            py = $signed(cell_board.org_y) + ((rs * u + rc * v) >>> 14);
            c.center_x = px[31:0];
            c.center_y = py[31:0];
            if (pick < 20)
                c.circle_radius = '0;
            else if (pick < 23)
                c.circle_radius = '1;
            else if (pick < 60)
                c.circle_radius = 31'($urandom_range(32'(span / 4)));
            else
                c.circle_radius = 31'($urandom_range(32'(span / 32) + 2));
        end
        return c;
    endfunction

    task automatic wait_drained();
        while (cell_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_circles(input int count, input int idle_pct, input int stall_in);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        repeat (count) send_circle(random_circle());
        circle_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        cell_board   = new();
        rst_n        = 1'b0;
        circle_valid = 1'b0;
        circle_data  = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset map: 256 x 256 cells of 5 cm
        send_circle(circle_t'{32'sd419430, 32'sd419430, 31'd0});
        send_circle(circle_t'{32'sd419430, 32'sd419430, 31'd131072});
        send_circle(circle_t'{32'sd0, 32'sd0, 31'd0});
        send_circle(circle_t'{32'sd0, 32'sd0, 31'd65536});
        send_circle(circle_t'{32'sd838860, 32'sd419430, 31'd0});
        send_circle(circle_t'{32'sd838861, 32'sd419430, 31'd0});
        send_circle(circle_t'{32'sd419430, 32'sd838861, 31'd32768});
        send_circle(circle_t'{-32'sd1, 32'sd419430, 31'd0});
        send_circle(circle_t'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'd0});
        send_circle(circle_t'{32'sh80000000, 32'sh80000000, 31'd0});
        send_circle(circle_t'{32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF});
        send_circle(circle_t'{32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF});
        send_circle(circle_t'{32'sd0, 32'sd0, 31'h7FFFFFFF});
        send_circle(circle_t'{32'sd419430, 32'sd419430, 31'd1});
        send_circle(circle_t'{32'shAAAAAAAA, 32'sh55555555, 31'h2AAAAAAA});
        send_circle(circle_t'{32'sh55555555, 32'shAAAAAAAA, 31'h55555555});
        send_circle(circle_t'{32'sd419430, 32'sd419430, 31'd400000});
        send_circle(circle_t'{32'sd3277, 32'sd3277, 31'd3277});
        run_circles(40, 0, 0);

        configure_map(13'd100, 13'd60, -32'sd163840, 32'sd81920, 16'sd16384, 16'sd0, 32'd655360);
        run_circles(50, 64, 0);

        // rotated by thirty degrees
        configure_map(13'd300, 13'd200, 32'sd327680, -32'sd196608, 16'sd14189, 16'sd8192,
                      32'd1310720);
        run_circles(50, 0, 64);

        // cell index wraps past 24 bits
        configure_map(13'd4096, 13'd8191, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 32'h0040_0000);
        run_circles(40, 27, 27);

        configure_map(13'd0, 13'd50, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 32'd1310720);
        run_circles(20, 64, 0);
        configure_map(13'd50, 13'd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 32'd1310720);
        run_circles(15, 0, 64);

        // zero scale, rotated by 135 degrees
        configure_map(13'd64, 13'd64, 32'sd65536, 32'sd65536, -16'sd11585, 16'sd11585, 32'd0);
        run_circles(30, 0, 64);

        configure_map(13'd1, 13'd1, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 32'd32768);
        run_circles(30, 27, 27);

        configure_map(13'd8191, 13'd8191, 32'sh80000000, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh8000,
                      32'hFFFF_FFFF);
        run_circles(30, 0, 0);
        configure_map(13'd8191, 13'd1, 32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 16'sh7FFF,
                      32'd1);
        run_circles(30, 64, 0);

        // output held off while circles keep coming
        configure_map(13'd256, 13'd256, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 32'd1310720);
        @(posedge clk);
        hold_off_left = HOLD_OFF_CYCLES;
        @(negedge clk);
        run_circles(50, 0, 27);

        // map turned half a revolution
        configure_map(13'd200, 13'd150, -32'sd196608, -32'sd131072, -16'sd16384, 16'sd0,
                      32'd655360);
        run_circles(40, 27, 27);

        if (cell_board.mismatches == 0 && cell_board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
